/* design/tidc_pkg.sv */
// ----------------------------------------------------------------------------
// tidc_pkg
// Shared types and codes for the timed id-to-value cache.
// ----------------------------------------------------------------------------
package tidc_pkg;

  localparam int PID_W   = 32;
  localparam int VALUE_W = 64;
  localparam int TIME_W  = 63;

  localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [1:0] FUNC_INSERT  = 2'd1;
  localparam logic [1:0] FUNC_INV_ALL = 2'd2;
  localparam logic [1:0] FUNC_INV_ONE = 2'd3;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(50000000);
  localparam logic [TIME_W-1:0] STAMP_MAX     = {TIME_W{1'b1}};

  // One stored slot, as kept in the entry memory.
  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [VALUE_W-1:0] value;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  // Per-entry compare results handed from the evaluator to the sequencer.
  typedef struct packed {
    logic pid_eq;
    logic live;
    logic older;
  } eval_t;

endpackage

/* design/timed_id_to_value_cache_core.sv */
// ----------------------------------------------------------------------------
// timed_id_to_value_cache_core
// Fully associative cache of process id to 64-bit value with a time stamp
// per entry and a programmable lifetime.
// ----------------------------------------------------------------------------
// Usage: raise start with func, pid, new_value and now while busy is low.
// The result (hit, value) appears on the ports for exactly one cycle with
// done high; it is not held, so capture it on that cycle. Every request gives
// one result. A request that scans the entries reads one entry per cycle from
// the entry memory: the accept cycle issues the first read, then each cycle
// checks one entry, and done rises the cycle after the last entry checked.
// A scan checks at most ENTRIES entries; busy is high while entries are
// checked and low again when done rises. Invalidate-all, a zero pid and
// an insert of a zero value need no scan (done on the next cycle,
// busy stays low). A new request may be accepted in the cycle done is high.
// The timeout register is written through cfg_valid/cfg_data, always ready;
// write it only while the cache is idle.
// ----------------------------------------------------------------------------
module timed_id_to_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic [tidc_pkg::PID_W-1:0]       pid,
  input  logic [tidc_pkg::VALUE_W-1:0]     new_value,
  input  logic [tidc_pkg::TIME_W-1:0]      now,
  // result channel
  output logic                             done,
  output logic                             hit,
  output logic [tidc_pkg::VALUE_W-1:0]     value,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tidc_pkg::TIME_W-1:0]      cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                           state;
  logic [ENTRIES-1:0]             valid;
  logic [tidc_pkg::TIME_W-1:0]    timeout;

  // latched request
  logic [1:0]                     req_func;
  logic [tidc_pkg::PID_W-1:0]     req_pid;
  logic [tidc_pkg::VALUE_W-1:0]   req_value;
  logic [tidc_pkg::TIME_W-1:0]    req_now;

  // scan state
  logic [AW-1:0]                  cmp_idx;
  logic [tidc_pkg::TIME_W-1:0]    oldest;
  logic [AW-1:0]                  victim;

  tidc_pkg::entry_t               rd_data;
  tidc_pkg::entry_t               wr_data;
  tidc_pkg::eval_t                ev;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [AW-1:0]                  wr_slot;

  logic                           accept;
  logic                           quick;
  logic                           last;
  logic                           cur_v;
  logic                           match;
  logic                           fin;
  logic                           fin_hit;
  logic                           clr_cur;

  assign busy      = (state == ST_RUN);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Requests that never touch the memory finish right away.
  assign quick = (func == tidc_pkg::FUNC_INV_ALL) || (pid == '0) ||
                 ((func == tidc_pkg::FUNC_INSERT) && (new_value == '0));

  // Read entry 0 on accept, then the entry after the one being checked.
  assign rd_addr = (state == ST_IDLE) ? '0 : AW'(cmp_idx + 1'b1);

  tidc_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tidc_eval u_eval (
    .entry   (rd_data),
    .pid     (req_pid),
    .now     (req_now),
    .timeout (timeout),
    .oldest  (oldest),
    .res     (ev)
  );

  assign last  = (cmp_idx == LAST_IDX);
  assign cur_v = valid[cmp_idx];
  assign match = cur_v && ev.pid_eq;

  always_comb begin
    wr_data.pid   = req_pid;
    wr_data.value = req_value;
    wr_data.stamp = req_now;
  end

  // Decide what the entry under check does to the scan.
  always_comb begin
    fin     = 1'b0;
    fin_hit = 1'b0;
    clr_cur = 1'b0;
    wr_en   = 1'b0;
    wr_slot = cmp_idx;
    if (state == ST_RUN) begin
      case (req_func)
        tidc_pkg::FUNC_LOOKUP: begin
          if (match && ev.live) begin
            fin     = 1'b1;
            fin_hit = 1'b1;
          end else begin
            // drop an expired entry with the same id
            clr_cur = match;
            fin     = last;
          end
        end
        tidc_pkg::FUNC_INSERT: begin
          if (!cur_v || ev.pid_eq) begin
            wr_en = 1'b1;
            fin   = 1'b1;
          end else if (last) begin
            // cache full: evict the oldest entry; on a tie the lowest index wins
            wr_en   = 1'b1;
            wr_slot = ev.older ? cmp_idx : victim;
            fin     = 1'b1;
          end
        end
        tidc_pkg::FUNC_INV_ONE: begin
          clr_cur = match;
          fin     = match || last;
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
  end

  // Control: state, valid bits, result strobe, timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      done    <= 1'b0;
      timeout <= tidc_pkg::TIMEOUT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (accept) begin
        if (quick) begin
          done <= 1'b1;
          if (func == tidc_pkg::FUNC_INV_ALL) begin
            valid <= '0;
          end
        end else begin
          state <= ST_RUN;
        end
      end
      if (state == ST_RUN) begin
        if (clr_cur) begin
          valid[cmp_idx] <= 1'b0;
        end
        if (wr_en) begin
          valid[wr_slot] <= 1'b1;
        end
        if (fin) begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
      end
    end
  end

  // Payload: request latch, scan position, victim tracking, result data.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func;
      req_pid   <= pid;
      req_value <= new_value;
      req_now   <= now;
      cmp_idx   <= '0;
      oldest    <= tidc_pkg::STAMP_MAX;
      victim    <= '0;
      hit       <= 1'b0;
      value     <= '0;
    end
    if (state == ST_RUN) begin
      // advance the scan; data for the next entry lands next cycle
      cmp_idx <= AW'(cmp_idx + 1'b1);
      if (ev.older) begin
        oldest <= rd_data.stamp;
        victim <= cmp_idx;
      end
      if (fin) begin
        hit   <= fin_hit;
        value <= fin_hit ? rd_data.value : '0;
      end
    end
  end

endmodule

/* design/tidc_mem.sv */
// ----------------------------------------------------------------------------
// tidc_mem
// Single-port-write, single-read entry memory with a registered read.
// ----------------------------------------------------------------------------
module tidc_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  tidc_pkg::entry_t  wr_data,
  input  logic [AW-1:0]     rd_addr,
  output tidc_pkg::entry_t  rd_data
);

  tidc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/tidc_eval.sv */
// ----------------------------------------------------------------------------
// tidc_eval
// Compare one stored entry against the request: id match, liveness and age
// order against the oldest stamp seen so far.
// ----------------------------------------------------------------------------
module tidc_eval (
  input  tidc_pkg::entry_t                  entry,
  input  logic [tidc_pkg::PID_W-1:0]        pid,
  input  logic [tidc_pkg::TIME_W-1:0]       now,
  input  logic [tidc_pkg::TIME_W-1:0]       timeout,
  input  logic [tidc_pkg::TIME_W-1:0]       oldest,
  output tidc_pkg::eval_t                   res
);

  logic [tidc_pkg::TIME_W-1:0] age;

  assign age = now - entry.stamp;

  always_comb begin
    res.pid_eq = (entry.pid == pid);
    // a stamp in the future counts as live
    res.live   = (now < entry.stamp) || (age < timeout);
    res.older  = (entry.stamp < oldest);
  end

endmodule
